/* src/serial_keyword_command_decoder_top_assert.svh */
// Assertion macros shared by the serial keyword command decoder modules.
`ifndef SERIAL_KEYWORD_COMMAND_DECODER_TOP_ASSERT_SVH
`define SERIAL_KEYWORD_COMMAND_DECODER_TOP_ASSERT_SVH

// Check a property on every rising clk edge outside reset.
`define SKD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define SKD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

/* src/skd_pkg.sv */
// Shared types, command codes and keyword tables for the keyword command decoder.
package skd_pkg;

  localparam int NUM_KEYS   = 14;
  localparam int TAIL_DEPTH = 5;

  localparam int DEF_COUNT_LIMIT = 200;
  localparam int DEF_QUEUE_DEPTH = 4;

  typedef logic [3:0] cmd_t;

  localparam cmd_t CMD_BZON  = 4'd0;
  localparam cmd_t CMD_BZOFF = 4'd1;
  localparam cmd_t CMD_XJON  = 4'd2;
  localparam cmd_t CMD_XJOFF = 4'd3;
  localparam cmd_t CMD_Q     = 4'd4;
  localparam cmd_t CMD_H     = 4'd5;
  localparam cmd_t CMD_Z     = 4'd6;
  localparam cmd_t CMD_Y     = 4'd7;
  localparam cmd_t CMD_T     = 4'd8;
  localparam cmd_t CMD_ZY    = 4'd9;
  localparam cmd_t CMD_YY    = 4'd10;
  localparam cmd_t CMD_SY    = 4'd11;
  localparam cmd_t CMD_XY    = 4'd12;
  localparam cmd_t CMD_GWSXT = 4'd13;

  // One decoded command request between the front end, the queue and the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  // Keyword lengths in table order.
  localparam logic [2:0] KEY_LEN [NUM_KEYS] = '{
    3'd4, 3'd5, 3'd4, 3'd5, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd5
  };

  // Keyword bytes as they sit in the tail: position 0 holds the last character.
  localparam logic [7:0] KEY_TAIL [NUM_KEYS][TAIL_DEPTH] = '{
    '{"n", "o", "z", "b", 8'h00},
    '{"f", "f", "o", "z", "b"},
    '{"n", "o", "j", "x", 8'h00},
    '{"f", "f", "o", "j", "x"},
    '{"Q", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"H", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"Z", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"Y", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"y", "z", 8'h00, 8'h00, 8'h00},
    '{"y", "y", 8'h00, 8'h00, 8'h00},
    '{"y", "s", 8'h00, 8'h00, 8'h00},
    '{"y", "x", 8'h00, 8'h00, 8'h00},
    '{"t", "x", "s", "w", "g"}
  };

  localparam logic [7:0] ANGLE_MAX  = 8'd180;
  localparam logic [7:0] ANGLE_STEP = 8'd20;
  localparam logic [7:0] CLAMP_LOW  = 8'd5;
  localparam logic [7:0] PAN_MIN    = 8'd0;
  localparam logic [7:0] TILT_MIN   = 8'd10;
  localparam logic [7:0] PAN_HOME   = 8'd90;
  localparam logic [7:0] TILT_HOME  = 8'd80;

  localparam logic signed [7:0] DRIVE_FWD  = 8'sd100;
  localparam logic signed [7:0] DRIVE_REV  = -8'sd100;
  localparam logic signed [7:0] DRIVE_STOP = 8'sd0;

endpackage

/* src/skd_front.sv */
// Front end: byte tail, byte counter and priority keyword match.
module skd_front #(
  parameter int COUNT_LIMIT = skd_pkg::DEF_COUNT_LIMIT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_accept,
  input  logic [7:0]        rx_byte,
  output skd_pkg::cmd_req_t push
);
  import skd_pkg::*;

  logic [7:0] tail_r   [TAIL_DEPTH-1];
  logic [7:0] tail_nxt [TAIL_DEPTH];
  logic [7:0] count_r, count_nxt, count_inc;
  logic [NUM_KEYS-1:0] key_hit;
  logic       any_hit;
  cmd_t       hit_cmd;

  always_comb begin
    tail_nxt[0] = rx_byte;
    for (int j = 1; j < TAIL_DEPTH; j++) begin
      tail_nxt[j] = tail_r[j-1];
    end
    count_inc = count_r + 8'd1;
  end

  // All fourteen compares run side by side; lowest index wins.
  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_hit[k] = (count_inc >= {5'd0, KEY_LEN[k]});
      for (int j = 0; j < TAIL_DEPTH; j++) begin
        if ((3'(j) < KEY_LEN[k]) && (tail_nxt[j] != KEY_TAIL[k][j])) begin
          key_hit[k] = 1'b0;
        end
      end
    end
    any_hit = 1'b0;
    hit_cmd = CMD_BZON;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (key_hit[k]) begin
        any_hit = 1'b1;
        hit_cmd = 4'(k);
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (byte_accept) begin
      if (any_hit || (count_inc >= 8'(COUNT_LIMIT))) begin
        count_nxt = 8'd0;
      end else begin
        count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 8'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Tail bytes need no reset: the counter gates every compare.
  always_ff @(posedge clk) begin
    if (byte_accept) begin
      for (int j = 0; j < TAIL_DEPTH - 1; j++) begin
        tail_r[j] <= tail_nxt[j];
      end
    end
  end

  assign push.valid = byte_accept && any_hit;
  assign push.cmd   = hit_cmd;

endmodule

/* src/skd_cmd_fifo.sv */
// Short command queue between the front end and the back end.
module skd_cmd_fifo #(
  parameter int QUEUE_DEPTH = skd_pkg::DEF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  skd_pkg::cmd_req_t push,
  input  logic              pop,
  output skd_pkg::cmd_req_t head,
  output logic              full
);
  import skd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign do_push = push.valid && !full;
  assign do_pop  = pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.cmd;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.cmd   = slot_r[rd_ptr_r];

`include "serial_keyword_command_decoder_top_assert.svh"

  `SKD_ASSERT(a_cnt_range, cnt_r <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
  `SKD_NEVER(a_push_full, push.valid && full, "command pushed into a full queue")
  `SKD_NEVER(a_pop_empty, pop && !head.valid, "command popped from an empty queue")

endmodule

/* src/skd_back.sv */
// Back end: mode flags, camera angles, drive values and the output register.
module skd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  skd_pkg::cmd_req_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output skd_pkg::cmd_t     cmd_out,
  output logic              upd_out,
  output logic signed [7:0] left_out,
  output logic signed [7:0] right_out,
  output logic              avoid_out,
  output logic              line_out,
  output logic [7:0]        pan_out,
  output logic [7:0]        tilt_out
);
  import skd_pkg::*;

  logic              out_valid_r, out_valid_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic              upd_r, upd_nxt;
  logic signed [7:0] left_r, left_nxt, right_r, right_nxt;
  logic              avoid_r, avoid_nxt, line_r, line_nxt;
  logic [7:0]        pan_r, pan_nxt, tilt_r, tilt_nxt;

  // Take the next command when the output slot is empty or being drained.
  assign pop = head.valid && (!out_valid_r || out_ready);

  always_comb begin
    cmd_nxt   = cmd_r;
    upd_nxt   = upd_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    avoid_nxt = avoid_r;
    line_nxt  = line_r;
    pan_nxt   = pan_r;
    tilt_nxt  = tilt_r;
    if (pop) begin
      cmd_nxt   = head.cmd;
      upd_nxt   = 1'b0;
      left_nxt  = DRIVE_STOP;
      right_nxt = DRIVE_STOP;
      unique case (head.cmd)
        CMD_BZON:  avoid_nxt = 1'b1;
        CMD_BZOFF: avoid_nxt = 1'b0;
        CMD_XJON:  line_nxt  = 1'b1;
        CMD_XJOFF: line_nxt  = 1'b0;
        CMD_Q: begin
          upd_nxt = 1'b1; left_nxt = DRIVE_FWD; right_nxt = DRIVE_FWD;
        end
        CMD_H: begin
          upd_nxt = 1'b1; left_nxt = DRIVE_REV; right_nxt = DRIVE_REV;
        end
        CMD_Z: begin
          upd_nxt = 1'b1; left_nxt = DRIVE_REV; right_nxt = DRIVE_FWD;
        end
        CMD_Y: begin
          upd_nxt = 1'b1; left_nxt = DRIVE_FWD; right_nxt = DRIVE_REV;
        end
        CMD_T: begin
          upd_nxt = 1'b1;
        end
        CMD_ZY: pan_nxt = (pan_r > ANGLE_MAX - ANGLE_STEP) ? ANGLE_MAX : pan_r + ANGLE_STEP;
        CMD_YY: pan_nxt = (pan_r < CLAMP_LOW + ANGLE_STEP) ? PAN_MIN : pan_r - ANGLE_STEP;
        CMD_SY: tilt_nxt = (tilt_r < CLAMP_LOW + ANGLE_STEP) ? TILT_MIN : tilt_r - ANGLE_STEP;
        CMD_XY: tilt_nxt = (tilt_r >= ANGLE_MAX - ANGLE_STEP) ? ANGLE_MAX
                                                              : tilt_r + ANGLE_STEP;
        CMD_GWSXT: begin
          pan_nxt  = PAN_HOME;
          tilt_nxt = TILT_HOME;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      avoid_r     <= 1'b0;
      line_r      <= 1'b0;
      pan_r       <= PAN_HOME;
      tilt_r      <= TILT_HOME;
    end else begin
      out_valid_r <= out_valid_nxt;
      avoid_r     <= avoid_nxt;
      line_r      <= line_nxt;
      pan_r       <= pan_nxt;
      tilt_r      <= tilt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    upd_r   <= upd_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
  end

  assign out_valid = out_valid_r;
  assign cmd_out   = cmd_r;
  assign upd_out   = upd_r;
  assign left_out  = left_r;
  assign right_out = right_r;
  // The state registers hold the post-command values until the next pop.
  assign avoid_out = avoid_r;
  assign line_out  = line_r;
  assign pan_out   = pan_r;
  assign tilt_out  = tilt_r;

`include "serial_keyword_command_decoder_top_assert.svh"

  `SKD_ASSERT(a_pop_loads, pop |=> out_valid_r, "popped command not presented")
  `SKD_ASSERT(a_drive_code, out_valid_r && upd_r |-> cmd_r >= CMD_Q && cmd_r <= CMD_T, "bad drive")
  `SKD_ASSERT(a_pan_range, pan_r <= ANGLE_MAX, "pan angle out of range")
  `SKD_ASSERT(a_tilt_range, tilt_r >= TILT_MIN && tilt_r <= ANGLE_MAX, "tilt angle out of range")

endmodule

/* src/serial_keyword_command_decoder_top.sv */
// Top level of the serial keyword command decoder.
//
//  channel | dir | ports                       | request
//  --------+-----+-----------------------------+--------------------------------
//  in      | in  | in_tvalid/in_tready/in_tdata | one received serial byte
//  out     | out | out_tvalid/out_tready/       | one decoded command with the
//          |     | out_tdata/out_tuser          | drive, mode and camera state
//
//  One byte is taken per cycle while in_tready is high. A byte that completes a keyword
//  pushes its command into the queue when the byte is accepted; from the queue head it is
//  loaded into the output register once that register is empty or drained, raising out_tvalid.
//  Reset (rst_n low, synchronous) clears the counter, queue, flags and output
//  valid, and homes the camera to pan 90, tilt 80; bytes with no match produce nothing.
//  When out stalls, the queue fills; in_tready drops once it holds QUEUE_DEPTH commands.
module serial_keyword_command_decoder_top #(
  parameter int COUNT_LIMIT = skd_pkg::DEF_COUNT_LIMIT,
  parameter int QUEUE_DEPTH = skd_pkg::DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] drive_left, [15:8] drive_right, [16] avoid_mode, [17] line_mode,
  // [25:18] pan_angle, [33:26] tilt_angle, [39:34] zero
  output logic [39:0] out_tdata,
  output logic [4:0]  out_tuser   // [3:0] matched_command, [4] drive_update
);
  import skd_pkg::*;

  cmd_req_t          push, head;
  logic              q_full, pop, byte_accept;
  cmd_t              cmd_out;
  logic              upd_out, avoid_out, line_out;
  logic signed [7:0] left_out, right_out;
  logic [7:0]        pan_out, tilt_out;

  // Accept a byte whenever the queue has room for a possible command.
  assign in_tready   = !q_full;
  assign byte_accept = in_tvalid && in_tready;

  skd_front #(
    .COUNT_LIMIT(COUNT_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_accept(byte_accept),
    .rx_byte    (in_tdata),
    .push       (push)
  );

  skd_cmd_fifo #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (q_full)
  );

  skd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .cmd_out  (cmd_out),
    .upd_out  (upd_out),
    .left_out (left_out),
    .right_out(right_out),
    .avoid_out(avoid_out),
    .line_out (line_out),
    .pan_out  (pan_out),
    .tilt_out (tilt_out)
  );

  // Pack the result fields, lowest field first.
  assign out_tdata = {6'd0, tilt_out, pan_out, line_out, avoid_out, right_out, left_out};
  assign out_tuser = {upd_out, cmd_out};

endmodule

/* bench/testbench.sv */
// Self-checking bench for the serial keyword command decoder: byte stream in, commands out.
`timescale 1ns / 100ps

module testbench;
  import skd_pkg::*;

  // Count limit and sizes of the stimulus.
  localparam int WRAP_AT      = DEF_COUNT_LIMIT;
  localparam int RANDOM_BYTES = 90;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_OFF_CYCLES = 40;

  // Camera and drive values the predictor works with.
  localparam int STEP_DEG  = 20;
  localparam int PAN_HOME  = 90;
  localparam int TILT_HOME = 80;
  localparam int DRIVE_MAG = 100;

  // One decoded command as it should leave the block.
  typedef struct packed {
    cmd_t       cmd;
    logic       upd;
    logic [7:0] left;
    logic [7:0] right;
    logic       avoid;
    logic       line;
    logic [7:0] pan;
    logic [7:0] tilt;
  } decoded_cmd_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [4:0]  out_tuser;

  // Keywords in priority order; position matches the command code.
  string keyword_text [NUM_KEYS] = '{
    "bzon", "bzoff", "xjon", "xjoff", "Q", "H", "Z", "Y", "T",
    "zy", "yy", "sy", "xy", "gwsxt"
  };

  // Predictor state: byte history, count since the last match, flags, angles.
  logic [7:0] rx_tail [TAIL_DEPTH];
  int         since_clear;
  logic       obstacle_flag;
  logic       line_flag;
  logic [7:0] pan_deg;
  logic [7:0] tilt_deg;

  decoded_cmd_t decoded_q [$];

  // Idle control shared between the stimulus and the receiver process.
  bit in_idle_en  = 1'b1;
  bit out_idle_en = 1'b1;
  int out_pause;
  int hold_out_cycles;

  int errors;
  int bytes_sent;
  int results_seen;

  serial_keyword_command_decoder_top #(
    .COUNT_LIMIT(WRAP_AT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Pan: above 180 saturates, anything under 5 (negatives too) snaps to 0.
  function automatic logic [7:0] clamp_pan(input int v);
    if (v > 180) return 8'd180;
    if (v < 5) return 8'd0;
    return 8'(v);
  endfunction

  // Tilt: 180 or more saturates, anything under 5 snaps to 10.
  function automatic logic [7:0] clamp_tilt(input int v);
    if (v >= 180) return 8'd180;
    if (v < 5) return 8'd10;
    return 8'(v);
  endfunction

  function automatic void reset_predictor();
    foreach (rx_tail[i]) rx_tail[i] = 8'h00;
    since_clear   = 0;
    obstacle_flag = 1'b0;
    line_flag     = 1'b0;
    pan_deg       = 8'(PAN_HOME);
    tilt_deg      = 8'(TILT_HOME);
  endfunction

  // Advance the predictor by one byte; return 1 and fill cmd when a keyword completes.
  function automatic bit decode_rx_byte(input logic [7:0] b, output decoded_cmd_t cmd);
    int hit;
    int n;
    bit same;
    for (int i = TAIL_DEPTH - 1; i > 0; i--) rx_tail[i] = rx_tail[i - 1];
    rx_tail[0] = b;
    since_clear++;
    cmd = '0;
    hit = -1;
    // Only bytes taken since the last match may form a keyword.
    for (int k = 0; k < NUM_KEYS && hit < 0; k++) begin
      n = keyword_text[k].len();
      if (since_clear >= n) begin
        same = 1'b1;
        for (int i = 0; i < n; i++)
          if (rx_tail[n - 1 - i] != keyword_text[k].getc(i)) same = 1'b0;
        if (same) hit = k;
      end
    end
    if (hit < 0) begin
      if (since_clear >= WRAP_AT) since_clear = 0;
      return 1'b0;
    end
    since_clear = 0;
    cmd.cmd = cmd_t'(hit);
    case (cmd.cmd)
      CMD_BZON:  obstacle_flag = 1'b1;
      CMD_BZOFF: obstacle_flag = 1'b0;
      CMD_XJON:  line_flag = 1'b1;
      CMD_XJOFF: line_flag = 1'b0;
      CMD_Q: begin
        cmd.upd = 1'b1; cmd.left = 8'(DRIVE_MAG); cmd.right = 8'(DRIVE_MAG);
      end
      CMD_H: begin
        cmd.upd = 1'b1; cmd.left = 8'(-DRIVE_MAG); cmd.right = 8'(-DRIVE_MAG);
      end
      CMD_Z: begin
        cmd.upd = 1'b1; cmd.left = 8'(-DRIVE_MAG); cmd.right = 8'(DRIVE_MAG);
      end
      CMD_Y: begin
        cmd.upd = 1'b1; cmd.left = 8'(DRIVE_MAG); cmd.right = 8'(-DRIVE_MAG);
      end
      CMD_T:     cmd.upd = 1'b1;
      CMD_ZY:    pan_deg = clamp_pan(int'(pan_deg) + STEP_DEG);
      CMD_YY:    pan_deg = clamp_pan(int'(pan_deg) - STEP_DEG);
      CMD_SY:    tilt_deg = clamp_tilt(int'(tilt_deg) - STEP_DEG);
      CMD_XY:    tilt_deg = clamp_tilt(int'(tilt_deg) + STEP_DEG);
      CMD_GWSXT: begin
        pan_deg = 8'(PAN_HOME); tilt_deg = 8'(TILT_HOME);
      end
      default: ;
    endcase
    cmd.avoid = obstacle_flag;
    cmd.line  = line_flag;
    cmd.pan   = pan_deg;
    cmd.tilt  = tilt_deg;
    return 1'b1;
  endfunction

  // Offer one byte after a random gap and hold it until the block takes it.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    decoded_cmd_t cmd;
    gap = in_idle_en ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    if (decode_rx_byte(b, cmd)) decoded_q.push_back(cmd);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s.getc(i));
  endtask

  // Stop offering and wait until every predicted command has come out.
  task automatic wait_all_decoded();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // A byte that cannot end any keyword, so it never triggers a match.
  function automatic logic [7:0] filler_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b inside {"n", "f", "t", "y", "Q", "H", "Z", "Y", "T"});
    return b;
  endfunction

  task automatic test_mode_flags();
    send_text("bzonxjonbzoffxjoff");
    wait_all_decoded();
  endtask

  task automatic test_drive_commands();
    send_text("QHZYT");
    wait_all_decoded();
  endtask

  // "zyyy" gives zy then yy: the middle y belongs to the cleared count.
  task automatic test_camera_commands();
    send_text("zyyysyxygwsxt");
    wait_all_decoded();
  endtask

  // A short keyword inside a long one wins and kills the long one; bytes 0x00 and 0xFF.
  task automatic test_interrupted_keywords();
    send_text("bzQon");
    send_text("xjo");
    send_byte(8'hFF);
    send_byte(8'h00);
    send_text("n");
    wait_all_decoded();
  endtask

  // Keyword ending exactly at the limit, then one split by the wrap.
  task automatic test_count_wrap();
    send_text("T");
    repeat (WRAP_AT - 4) send_byte(filler_byte());
    send_text("bzon");
    repeat (WRAP_AT - 3) send_byte(filler_byte());
    send_text("bzon");
    send_text("bzon");
    wait_all_decoded();
  endtask

  // Hold the output off while commands stream in, so the queue fills and in_tready drops.
  task automatic test_back_pressure();
    in_idle_en = 1'b0;
    hold_out_cycles = HOLD_OFF_CYCLES;
    send_text("QHZYTQHZYTQH");
    wait_all_decoded();
    in_idle_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    int start;
    int k;
    int pick;
    int cut;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      // Switch idling on and off in stretches.
      if ($urandom_range(0, 39) == 0) begin
        in_idle_en  = $urandom_range(0, 2) != 0;
        out_idle_en = $urandom_range(0, 2) != 0;
      end
      if ($urandom_range(0, 29) == 0) wait_all_decoded();
      pick = $urandom_range(0, 9);
      k = $urandom_range(0, NUM_KEYS - 1);
      if (pick < 6) begin
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
        send_text(keyword_text[k]);
      end else if (pick < 8) begin
        // Run of one camera keyword to drive the angles into their clamps.
        k = int'(CMD_ZY) + $urandom_range(0, 4);
        repeat ($urandom_range(1, 8)) send_text(keyword_text[k]);
      end else if (pick == 8) begin
        // Corrupt one byte of a keyword.
        cut = $urandom_range(0, keyword_text[k].len() - 1);
        for (int i = 0; i < keyword_text[k].len(); i++)
          send_byte(i == cut ? 8'($urandom_range(0, 255)) : keyword_text[k].getc(i));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
    end
    wait_all_decoded();
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  // Receiver: drop tready for a random pause after each request, or for a long hold-off.
  initial begin
    out_tready = 1'b0;
    out_pause = 0;
    hold_out_cycles = 0;
    forever begin
      @(negedge clk);
      if (hold_out_cycles > 0) begin
        out_tready <= 1'b0;
        hold_out_cycles--;
      end else if (out_pause > 0) begin
        out_tready <= 1'b0;
        out_pause--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Compare every accepted request with the oldest prediction.
  always @(posedge clk) begin
    decoded_cmd_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      out_pause = out_idle_en ? $urandom_range(0, 4) : 0;
      if (decoded_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected command, expected none, actual cmd %0d",
                 $time, out_tuser[3:0]);
      end else begin
        want = decoded_q.pop_front();
        check_field("matched_command", want.cmd, out_tuser[3:0]);
        check_field("drive_update", want.upd, out_tuser[4]);
        check_field("drive_left", $signed(want.left), $signed(out_tdata[7:0]));
        check_field("drive_right", $signed(want.right), $signed(out_tdata[15:8]));
        check_field("avoid_mode", want.avoid, out_tdata[16]);
        check_field("line_mode", want.line, out_tdata[17]);
        check_field("pan_angle", want.pan, out_tdata[25:18]);
        check_field("tilt_angle", want.tilt, out_tdata[33:26]);
        check_field("tdata padding", 0, out_tdata[39:34]);
      end
    end
  end

  // Main sequence: reset once, run each test in turn, then settle and report.
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    errors = 0;
    bytes_sent = 0;
    results_seen = 0;
    reset_predictor();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_mode_flags();
    test_drive_commands();
    test_camera_commands();
    test_interrupted_keywords();
    test_count_wrap();
    test_back_pressure();
    test_random_traffic();

    // Leave room for anything the block should not have produced.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (decoded_q.size() != 0) begin
      errors++;
      $display("%0t: %0d commands still outstanding, expected 0", $time, decoded_q.size());
    end
    $display("Sent %0d bytes, checked %0d commands: all keywords, broken keywords,",
             bytes_sent, results_seen);
    $display("angle clamps, count wrap at %0d and a long output hold-off.", WRAP_AT);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
